/* src/ptq_pkg.sv */
// Shared constants, codes and types of the periodic timer queue.
package ptq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int IDX_W = $clog2(TIMER_SLOTS);
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    localparam int TYPE_W = 2;
    localparam int SLOT_W = 4;
    localparam int TIME_W = 63;
    localparam int IVL_W = 40;
    localparam int MIN_W = 20;
    localparam int STAT_W = 2;

    localparam logic [MIN_W-1:0] MIN_DELAY_RESET = MIN_W'(100);

    localparam logic [TYPE_W-1:0] REQ_ADD = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_CANCEL = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_TICK = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_ACTIVE = 2'd1;
    localparam logic [STAT_W-1:0] ST_ALREADY_ACTIVE = 2'd2;

    typedef enum logic [0:0] {
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRESCAN,
        S_ADD_WR,
        S_EXPSCAN,
        S_PICK,
        S_REARM,
        S_MINSCAN,
        S_DELAY,
        S_CLAMP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [SLOT_W-1:0] timer_slot;
        logic [TIME_W-1:0] expiration;
        logic [IVL_W-1:0]  interval;
        logic [TIME_W-1:0] current_time;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              fired;
        logic [SLOT_W-1:0] fired_slot;
        logic              rearmed;
        logic              earliest_changed;
        logic              next_valid;
        logic [TIME_W-1:0] next_deadline;
        logic [TIME_W-1:0] arm_delay;
        logic              last;
    } res_t;

endpackage

/* src/periodic_timer_queue_top.sv */
// Top level of the periodic timer queue: ports, configuration register and result register.
//
// A request enters on req_valid/req_stall with req_type, timer_slot, expiration,
// interval and current_time; it is taken at an edge with req_valid high and req_stall low.
// Results leave on rsp_valid/rsp_stall, one per add, cancel or idle request, and one per
// fired slot on a tick (a single result if none fires); last marks the final one.
// The minimum arming delay is written on cfg_valid/cfg_ready/cfg_data while idle, a rule
// for the user that the block does not enforce. Every slot scan walks the sixteen slots
// one per cycle through one shared 64-bit adder, and an add, cancel or tick ends with a
// scan for the new minimum. Results stream one per cycle, but while rsp_stall is high the
// output register keeps its result and the sequencer waits. req_stall stays high until
// the last result has entered the output register. Reset leaves every slot inactive and
// sets the minimum arming delay to 100 microseconds; no clearing pass is needed.
module periodic_timer_queue_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [ptq_pkg::TYPE_W-1:0]  req_type,
    input  logic [ptq_pkg::SLOT_W-1:0]  timer_slot,
    input  logic [ptq_pkg::TIME_W-1:0]  expiration,
    input  logic [ptq_pkg::IVL_W-1:0]   interval,
    input  logic [ptq_pkg::TIME_W-1:0]  current_time,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ptq_pkg::MIN_W-1:0]   cfg_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [ptq_pkg::STAT_W-1:0]  status,
    output logic                        fired,
    output logic [ptq_pkg::SLOT_W-1:0]  fired_slot,
    output logic                        rearmed,
    output logic                        earliest_changed,
    output logic                        next_valid,
    output logic [ptq_pkg::TIME_W-1:0]  next_deadline,
    output logic [ptq_pkg::TIME_W-1:0]  arm_delay,
    output logic                        last
);
    import ptq_pkg::*;

    logic               seq_ready;
    logic               seq_res_valid;
    logic               seq_res_ready;
    req_t               seq_req;
    res_t               seq_res;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_res_reg;
    logic               out_load;

    ptq_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (seq_ready),
        .req       (seq_req),
        .min_delay (min_reg),
        .res_valid (seq_res_valid),
        .res_ready (seq_res_ready),
        .res       (seq_res)
    );

    always_comb
    begin
        seq_req.req_type = req_type;
        seq_req.timer_slot = timer_slot;
        seq_req.expiration = expiration;
        seq_req.interval = interval;
        seq_req.current_time = current_time;
        req_stall = !seq_ready;
        cfg_ready = 1'b1;
        min_next = (cfg_valid && cfg_ready) ? cfg_data : min_reg;
        seq_res_ready = !out_valid_reg || !rsp_stall;
        out_load = seq_res_valid && seq_res_ready;
        out_valid_next = out_load || (out_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_DELAY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_reg <= min_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg <= seq_res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status = out_res_reg.status;
    assign fired = out_res_reg.fired;
    assign fired_slot = out_res_reg.fired_slot;
    assign rearmed = out_res_reg.rearmed;
    assign earliest_changed = out_res_reg.earliest_changed;
    assign next_valid = out_res_reg.next_valid;
    assign next_deadline = out_res_reg.next_deadline;
    assign arm_delay = out_res_reg.arm_delay;
    assign last = out_res_reg.last;

endmodule

/* src/ptq_alu.sv */
// Shared 64-bit adder used for time compares, differences and saturating re-arm sums.
module ptq_alu (
    input  ptq_pkg::alu_op_t             op,
    input  logic [ptq_pkg::TIME_W-1:0]   a,
    input  logic [ptq_pkg::TIME_W-1:0]   b,
    output logic [ptq_pkg::TIME_W-1:0]   res,
    output logic                         msb
);
    import ptq_pkg::*;

    logic             sub;
    logic [TIME_W:0]  a_ext;
    logic [TIME_W:0]  b_ext;
    logic [TIME_W:0]  sum;

    always_comb
    begin
        sub = (op == ALU_SUB);
        a_ext = {1'b0, a};
        b_ext = sub ? ~{1'b0, b} : {1'b0, b};
        sum = a_ext + b_ext + {{TIME_W{1'b0}}, sub};
        msb = sum[TIME_W];
        res = (!sub && msb) ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    end

endmodule

/* src/ptq_seq.sv */
// Slot table and sequencer that scans the slots through the shared adder.
module ptq_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  ptq_pkg::req_t               req,
    input  logic [ptq_pkg::MIN_W-1:0]   min_delay,
    output logic                        res_valid,
    input  logic                        res_ready,
    output ptq_pkg::res_t               res
);
    import ptq_pkg::*;

    state_t                   state_reg, state_next;
    logic [TIMER_SLOTS-1:0]   active_reg, active_next;
    logic [TIMER_SLOTS-1:0]   expired_reg, expired_next;
    logic [TIMER_SLOTS-1:0]   again_reg, again_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         pick_reg, pick_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic                     any_reg, any_next;
    logic [TIME_W-1:0]        best_reg, best_next;
    logic [TIME_W-1:0]        delay_reg, delay_next;
    logic [STAT_W-1:0]        status_reg, status_next;
    logic                     changed_reg, changed_next;
    logic                     tick_reg, tick_next;
    req_t                     req_reg, req_next;

    logic [TIME_W-1:0]        exp_arr_reg [TIMER_SLOTS];
    logic [IVL_W-1:0]         ivl_arr_reg [TIMER_SLOTS];
    logic [IDX_W-1:0]         order_reg [TIMER_SLOTS];

    logic                     exp_we;
    logic [IDX_W-1:0]         exp_wr_addr;
    logic [TIME_W-1:0]        exp_next;
    logic                     ivl_we;
    logic                     order_we;

    logic [IDX_W-1:0]         rd_addr;
    logic [TIME_W-1:0]        exp_rd;
    logic [IVL_W-1:0]         ivl_rd;

    alu_op_t                  alu_op;
    logic [TIME_W-1:0]        alu_a;
    logic [TIME_W-1:0]        alu_b;
    logic [TIME_W-1:0]        alu_res;
    logic                     alu_msb;

    logic                     cand;
    logic                     take;
    logic                     any_scan;
    logic [TIME_W-1:0]        best_scan;
    logic [IDX_W-1:0]         pick_scan;
    logic                     scan_end;
    logic                     in_range;
    logic [IDX_W-1:0]         slot_idx;
    logic [IDX_W-1:0]         req_slot_idx;
    logic                     rearm;
    logic                     fire_mode;
    logic                     res_last;

    ptq_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .msb (alu_msb)
    );

    assign rd_addr = (state_reg == S_REARM) ? pick_reg : idx_reg;
    assign exp_rd = exp_arr_reg[rd_addr];
    assign ivl_rd = ivl_arr_reg[rd_addr];
    assign slot_idx = IDX_W'(req_reg.timer_slot);
    assign req_slot_idx = IDX_W'(req.timer_slot);
    assign in_range = int'(req.timer_slot) < TIMER_SLOTS;
    assign scan_end = (idx_reg == IDX_W'(TIMER_SLOTS - 1));
    assign rearm = |ivl_rd;
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        unique case (state_reg)
            S_EXPSCAN:
            begin
                alu_op = ALU_SUB;
                alu_a = req_reg.current_time;
                alu_b = exp_rd;
            end
            S_ADD_WR:
            begin
                alu_op = ALU_SUB;
                alu_a = req_reg.expiration;
                alu_b = best_reg;
            end
            S_REARM:
            begin
                alu_op = ALU_ADD;
                alu_a = req_reg.current_time;
                alu_b = {{(TIME_W - IVL_W){1'b0}}, ivl_rd};
            end
            S_DELAY:
            begin
                alu_op = ALU_SUB;
                alu_a = best_reg;
                alu_b = req_reg.current_time;
            end
            default:
            begin
                alu_op = ALU_SUB;
                alu_a = exp_rd;
                alu_b = best_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg) inside
            S_PRESCAN, S_MINSCAN: cand = active_reg[idx_reg];
            S_PICK:               cand = active_reg[idx_reg] && expired_reg[idx_reg];
            default:              cand = 1'b0;
        endcase
        take = cand && (!any_reg || alu_msb);
        any_scan = any_reg || take;
        best_scan = take ? exp_rd : best_reg;
        pick_scan = take ? idx_reg : pick_reg;
    end

    always_comb
    begin
        fire_mode = tick_reg && (n_reg != '0);
        res_last = !fire_mode || ((CNT_W'(idx_reg) + CNT_W'(1)) == n_reg);
        res.status = status_reg;
        res.fired = fire_mode;
        res.fired_slot = fire_mode ? SLOT_W'(order_reg[idx_reg]) : '0;
        res.rearmed = fire_mode && again_reg[idx_reg];
        res.earliest_changed = changed_reg;
        res.next_valid = any_reg;
        res.next_deadline = best_reg;
        res.arm_delay = delay_reg;
        res.last = res_last;
    end

    always_comb
    begin
        state_next = state_reg;
        active_next = active_reg;
        expired_next = expired_reg;
        again_next = again_reg;
        idx_next = idx_reg;
        pick_next = pick_reg;
        n_next = n_reg;
        any_next = any_reg;
        best_next = best_reg;
        delay_next = delay_reg;
        status_next = status_reg;
        changed_next = changed_reg;
        tick_next = tick_reg;
        req_next = req_reg;
        exp_we = 1'b0;
        exp_wr_addr = slot_idx;
        exp_next = req_reg.expiration;
        ivl_we = 1'b0;
        order_we = 1'b0;
        res_valid = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    idx_next = '0;
                    any_next = 1'b0;
                    best_next = '0;
                    n_next = '0;
                    status_next = ST_OK;
                    changed_next = 1'b0;
                    tick_next = (req.req_type == REQ_TICK);
                    unique case (req.req_type)
                        REQ_ADD:
                        begin
                            if (!in_range || active_reg[req_slot_idx])
                            begin
                                status_next = ST_ALREADY_ACTIVE;
                                state_next = S_MINSCAN;
                            end
                            else
                            begin
                                state_next = S_PRESCAN;
                            end
                        end
                        REQ_CANCEL:
                        begin
                            if (!in_range || !active_reg[req_slot_idx])
                            begin
                                status_next = ST_NOT_ACTIVE;
                            end
                            else
                            begin
                                active_next[req_slot_idx] = 1'b0;
                            end
                            state_next = S_MINSCAN;
                        end
                        REQ_TICK: state_next = S_EXPSCAN;
                        default:  state_next = S_MINSCAN;
                    endcase
                end
            end
            S_PRESCAN:
            begin
                any_next = any_scan;
                best_next = best_scan;
                idx_next = idx_reg + IDX_W'(1);
                if (scan_end)
                begin
                    state_next = S_ADD_WR;
                end
            end
            S_ADD_WR:
            begin
                changed_next = !any_reg || alu_msb;
                active_next[slot_idx] = 1'b1;
                exp_we = 1'b1;
                ivl_we = 1'b1;
                idx_next = '0;
                any_next = 1'b0;
                best_next = '0;
                state_next = S_MINSCAN;
            end
            S_EXPSCAN:
            begin
                expired_next[idx_reg] = active_reg[idx_reg] && !alu_msb;
                idx_next = idx_reg + IDX_W'(1);
                if (scan_end)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                any_next = any_scan;
                best_next = best_scan;
                pick_next = pick_scan;
                idx_next = idx_reg + IDX_W'(1);
                if (scan_end)
                begin
                    if (any_scan)
                    begin
                        state_next = S_REARM;
                    end
                    else
                    begin
                        any_next = 1'b0;
                        best_next = '0;
                        state_next = S_MINSCAN;
                    end
                end
            end
            S_REARM:
            begin
                exp_wr_addr = pick_reg;
                exp_next = alu_res;
                exp_we = rearm;
                if (!rearm)
                begin
                    active_next[pick_reg] = 1'b0;
                end
                expired_next[pick_reg] = 1'b0;
                order_we = 1'b1;
                again_next[n_reg[IDX_W-1:0]] = rearm;
                n_next = n_reg + CNT_W'(1);
                idx_next = '0;
                any_next = 1'b0;
                best_next = '0;
                state_next = S_PICK;
            end
            S_MINSCAN:
            begin
                any_next = any_scan;
                best_next = best_scan;
                idx_next = idx_reg + IDX_W'(1);
                if (scan_end)
                begin
                    state_next = S_DELAY;
                end
            end
            S_DELAY:
            begin
                delay_next = (any_reg && !alu_msb && (|alu_res)) ? alu_res : '0;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (any_reg && (delay_reg[TIME_W-1:MIN_W] == '0)
                    && (delay_reg[MIN_W-1:0] < min_delay))
                begin
                    delay_next = {{(TIME_W - MIN_W){1'b0}}, min_delay};
                end
                idx_next = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (res_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            active_reg <= '0;
            expired_reg <= '0;
            idx_reg <= '0;
            n_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            active_reg <= active_next;
            expired_reg <= expired_next;
            idx_reg <= idx_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        again_reg <= again_next;
        pick_reg <= pick_next;
        any_reg <= any_next;
        best_reg <= best_next;
        delay_reg <= delay_next;
        status_reg <= status_next;
        changed_reg <= changed_next;
        tick_reg <= tick_next;
        req_reg <= req_next;
        if (exp_we)
        begin
            exp_arr_reg[exp_wr_addr] <= exp_next;
        end
        if (ivl_we)
        begin
            ivl_arr_reg[slot_idx] <= req_reg.interval;
        end
        if (order_we)
        begin
            order_reg[n_reg[IDX_W-1:0]] <= pick_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(TIMER_SLOTS))
        else $error("More slots fired than the table holds.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REARM |=> !expired_reg[$past(pick_reg)])
        else $error("A fired slot is still marked as expired.");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !any_reg |-> best_reg == '0 && delay_reg == '0)
        else $error("Deadline or delay reported with no active slot.");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && any_reg |-> delay_reg >= {{(TIME_W - MIN_W){1'b0}}, min_delay})
        else $error("Arming delay below the configured minimum.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PICK && scan_end && any_scan |-> active_reg[pick_scan])
        else $error("Picked slot is not active.");

endmodule
